// ===== rtl/core/asm_operand_token_classifier_assert.svh =====
// Assertion macros for the operand token classifier.
`ifndef ASM_OPERAND_TOKEN_CLASSIFIER_ASSERT_SVH
`define ASM_OPERAND_TOKEN_CLASSIFIER_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define AOTC_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("aotc same-cycle check failed");

`define AOTC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("aotc next-cycle check failed");

`else

`define AOTC_ASSERT_SAME(lbl, clk, rst, ante, cons)

`define AOTC_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

// ===== rtl/core/aotc_pkg.sv =====
package aotc_pkg;

   localparam int AddressBitsDefault = 24;

   typedef enum logic [2:0] {
      CAT_REG        = 3'd0,
      CAT_DEC        = 3'd1,
      CAT_HEX        = 3'd2,
      CAT_ADDR       = 3'd3,
      CAT_TRIPLE     = 3'd4,
      CAT_STRING     = 3'd5,
      CAT_BYTE_SEL   = 3'd6,
      CAT_LABEL      = 3'd7
   } category_type;

   typedef enum logic [3:0] {
      ERR_NONE         = 4'd0,
      ERR_BAD_REG      = 4'd1,
      ERR_DEC_HIGH     = 4'd2,
      ERR_HEX_HIGH     = 4'd3,
      ERR_BAD_HEX      = 4'd4,
      ERR_ADDR_HIGH    = 4'd5,
      ERR_BAD_ADDR     = 4'd6,
      ERR_NO_BRACKET   = 4'd7,
      ERR_TRIPLE_FEW   = 4'd8,
      ERR_TRIPLE_MANY  = 4'd9,
      ERR_TRIPLE_REG   = 4'd10,
      ERR_NO_QUOTE     = 4'd11,
      ERR_BAD_BYTE_SEL = 4'd12
   } error_type;

   typedef enum logic [1:0] {
      BSEL_MSB = 2'd0,
      BSEL_MB  = 2'd1,
      BSEL_LSB = 2'd2
   } byte_sel_type;

   typedef struct packed {
      logic [7:0] char_in;
      logic       last;
   } req_payload_type;

   typedef struct packed {
      logic [2:0]  category;
      logic [3:0]  error_code;
      logic [23:0] value;
      logic [2:0]  reg_first;
      logic [2:0]  reg_second;
      logic [2:0]  reg_third;
      logic [1:0]  byte_select;
   } rsp_payload_type;

   // Token state as it stands after the current character is folded in.
   typedef struct packed {
      logic [2:0]      count;
      logic [3:0][7:0] head;
      logic            all_digits;
      logic            dec_over;
      logic [7:0]      dec_val;
      logic            short_over;
      logic [7:0]      short_val;
      logic            long_over;
      logic [23:0]     long_val;
      logic [1:0]      hex_flags;
      logic [2:0]      dot_state;
      logic [2:0][7:0] suffix;
   } scan_view_type;

   // Register letter to code; bit 3 set marks a character that is no register.
   function automatic logic [3:0] reg_code(input logic [7:0] c);
      logic [3:0] r;
      case (c)
         "a":     r = 4'd0;
         "b":     r = 4'd1;
         "c":     r = 4'd2;
         "d":     r = 4'd3;
         "i":     r = 4'd4;
         "j":     r = 4'd5;
         "x":     r = 4'd6;
         "y":     r = 4'd7;
         default: r = 4'd8;
      endcase
      return r;
   endfunction

   // Hex digit value; bit 4 set when the character is a hex digit.
   function automatic logic [4:0] hex_val(input logic [7:0] c);
      logic [4:0] h;
      if (c inside {["0":"9"]}) begin
         h = {1'b1, c[3:0]};
      end else if (c inside {["a":"f"], ["A":"F"]}) begin
         h = {1'b1, c[3:0] + 4'd9};
      end else begin
         h = 5'd0;
      end
      return h;
   endfunction

endpackage

// ===== rtl/core/asm_operand_token_classifier.sv =====
// A token's last character waits in the input register until the result register is free;
// its result is then registered in the result register, from which it transfers on rsp.
// Throughput: one character per cycle, but a last character holds on a stalled result.
// The rate is set by the per-character accumulate path in the scan stage.
// Reset (synchronous, active high) empties both pipeline registers and
// returns the token state to an empty token; no clearing pass is needed.
`include "asm_operand_token_classifier_assert.svh"

module asm_operand_token_classifier #(
   parameter int ADDRESS_BITS = aotc_pkg::AddressBitsDefault
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  aotc_pkg::req_payload_type req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output aotc_pkg::rsp_payload_type rsp_data
);
   import aotc_pkg::*;

   // input register
   logic            s1_valid_ff, s1_valid_in;
   logic [7:0]      s1_char_ff;
   logic            s1_last_ff;

   // result register
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_data_ff, rsp_data_in;

   logic            out_free;
   logic            advance;
   logic            req_take;
   logic            emit;
   logic            rsp_err;
   scan_view_type   view;
   logic [3:0]      r_single, r_a, r_b, r_c;
   logic [2:0]      sel_len;
   logic [7:0]      c;

   // A finished result can wait on rsp while the next characters stream in;
   // only a last character with a full, stalled result register has to hold.
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = s1_valid_ff && (!s1_last_ff || out_free);
   assign emit      = advance && s1_last_ff;
   assign req_stall = s1_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   aotc_scan #(
      .ADDRESS_BITS(ADDRESS_BITS)
   ) u_scan (
      .clock   (clock),
      .reset   (reset),
      .step    (advance),
      .clear   (s1_last_ff),
      .char_in (s1_char_ff),
      .view    (view)
   );

   // Classify the token from its state including the closing character.
   // Rules are tried in priority order; the first match wins.
   always_comb begin
      c        = s1_char_ff;
      r_single = reg_code(c);
      r_a      = reg_code(view.head[1]);
      r_b      = reg_code(view.head[2]);
      r_c      = reg_code(view.head[3]);
      sel_len  = view.dot_state - 3'd1;

      rsp_data_in             = '0;
      rsp_data_in.category    = CAT_LABEL;
      rsp_data_in.error_code  = ERR_NONE;

      if (view.count == 3'd1) begin
         rsp_data_in.category = CAT_REG;
         if (r_single[3]) begin
            rsp_data_in.error_code = ERR_BAD_REG;
         end else begin
            rsp_data_in.reg_first = r_single[2:0];
         end
      end else if (view.all_digits) begin
         rsp_data_in.category = CAT_DEC;
         if (view.dec_over) begin
            rsp_data_in.error_code = ERR_DEC_HIGH;
         end else begin
            rsp_data_in.value = {16'd0, view.dec_val};
         end
      end else if (view.head[0] == "0" && view.head[1] == "x") begin
         rsp_data_in.category = CAT_HEX;
         if (!view.hex_flags[0]) begin
            rsp_data_in.error_code = ERR_BAD_HEX;
         end else if (view.short_over) begin
            rsp_data_in.error_code = ERR_HEX_HIGH;
         end else begin
            rsp_data_in.value = {16'd0, view.short_val};
         end
      end else if (view.count >= 3'd3 && view.head[0] == "$" && view.head[1] == "0"
                   && view.head[2] == "x") begin
         rsp_data_in.category = CAT_ADDR;
         // a bare "$0x" has no digits and counts as a bad address
         if (view.count == 3'd3 || !view.hex_flags[1]) begin
            rsp_data_in.error_code = ERR_BAD_ADDR;
         end else if (view.long_over) begin
            rsp_data_in.error_code = ERR_ADDR_HIGH;
         end else begin
            rsp_data_in.value = view.long_val;
         end
      end else if (view.head[0] == "[") begin
         rsp_data_in.category = CAT_TRIPLE;
         if (c != "]") begin
            rsp_data_in.error_code = ERR_NO_BRACKET;
         end else if (view.count < 3'd5) begin
            rsp_data_in.error_code = ERR_TRIPLE_FEW;
         end else if (view.count > 3'd5) begin
            rsp_data_in.error_code = ERR_TRIPLE_MANY;
         end else if (r_a[3] || r_b[3] || r_c[3]) begin
            rsp_data_in.error_code = ERR_TRIPLE_REG;
         end else begin
            rsp_data_in.reg_first  = r_a[2:0];
            rsp_data_in.reg_second = r_b[2:0];
            rsp_data_in.reg_third  = r_c[2:0];
         end
      end else if (view.head[0] == "\"") begin
         rsp_data_in.category = CAT_STRING;
         if (c != "\"") begin
            rsp_data_in.error_code = ERR_NO_QUOTE;
         end
      end else if (view.dot_state != 3'd0) begin
         rsp_data_in.category = CAT_BYTE_SEL;
         if (sel_len == 3'd3 && view.suffix[0] == "m" && view.suffix[1] == "s"
             && view.suffix[2] == "b") begin
            rsp_data_in.byte_select = BSEL_MSB;
         end else if (sel_len == 3'd2 && view.suffix[0] == "m"
                      && view.suffix[1] == "b") begin
            rsp_data_in.byte_select = BSEL_MB;
         end else if (sel_len == 3'd3 && view.suffix[0] == "l" && view.suffix[1] == "s"
                      && view.suffix[2] == "b") begin
            rsp_data_in.byte_select = BSEL_LSB;
         end else begin
            rsp_data_in.error_code = ERR_BAD_BYTE_SEL;
         end
      end
   end

   // Advance the input register: load on transfer, drop once consumed.
   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_take) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
   end

   // Hold the result until it transfers; a new one may land the same cycle.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_char_ff <= req_data.char_in;
         s1_last_ff <= req_data.last;
      end
      if (emit) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign rsp_err = rsp_valid_ff && (rsp_data_ff.error_code != ERR_NONE);

   `AOTC_ASSERT_NEXT(a_emit_shows, clock, reset, emit, rsp_valid_ff)
   `AOTC_ASSERT_SAME(a_no_overwrite, clock, reset, rsp_valid_ff && rsp_stall, !emit)
   `AOTC_ASSERT_SAME(a_stall_needs_item, clock, reset, req_stall, s1_valid_ff && s1_last_ff)
   `AOTC_ASSERT_SAME(a_error_no_value, clock, reset, rsp_err, rsp_data_ff.value == 24'd0)

endmodule

// ===== rtl/core/aotc_scan.sv =====
module aotc_scan #(
   parameter int ADDRESS_BITS = aotc_pkg::AddressBitsDefault
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    step,
   input  logic                    clear,
   input  logic [7:0]              char_in,
   output aotc_pkg::scan_view_type view
);
   import aotc_pkg::*;

   localparam int LongW = ADDRESS_BITS + 1;
   localparam logic [LongW+3:0] LongSat = (LongW + 4)'(1) << ADDRESS_BITS;

   logic [2:0]       count_ff, count_in;
   logic [3:0][7:0]  head_ff, head_in;
   logic             all_digits_ff, all_digits_in;
   logic [8:0]       dec_ff, dec_in;
   logic [8:0]       short_ff, short_in;
   logic [LongW-1:0] long_ff, long_in;
   logic [1:0]       flags_ff, flags_in;
   logic [2:0]       dot_ff, dot_in;
   logic [2:0][7:0]  suffix_ff, suffix_in;

   logic             is_digit;
   logic [4:0]       hv;
   logic [11:0]      dec_sum;
   logic [12:0]      short_sum;
   logic [LongW+3:0] long_sum;
   logic [2:0]       k;
   logic [LongW+23:0] long_wide;

   always_comb begin
      is_digit  = char_in inside {["0":"9"]};
      hv        = hex_val(char_in);
      dec_sum   = {dec_ff, 3'b000} + {2'b00, dec_ff, 1'b0} + {8'd0, char_in[3:0]};
      short_sum = {short_ff, 4'b0000} + {9'd0, hv[3:0]};
      long_sum  = {long_ff, 4'b0000} + (LongW + 4)'(hv[3:0]);
      k         = dot_ff - 3'd1;

      count_in      = (count_ff == 3'd7) ? count_ff : count_ff + 3'd1;
      head_in       = head_ff;
      all_digits_in = all_digits_ff & is_digit;
      dec_in        = dec_ff;
      short_in      = short_ff;
      long_in       = long_ff;
      flags_in      = flags_ff;
      dot_in        = dot_ff;
      suffix_in     = suffix_ff;

      if (!count_ff[2]) begin
         head_in[count_ff[1:0]] = char_in;
      end
      if (is_digit) begin
         dec_in = (dec_sum > 12'd256) ? 9'd256 : dec_sum[8:0];
      end
      // hex value tail starts after "0x"
      if (count_ff >= 3'd2) begin
         if (!hv[4]) begin
            flags_in[0] = 1'b0;
         end else begin
            short_in = (short_sum > 13'd256) ? 9'd256 : short_sum[8:0];
         end
      end
      // address tail starts after "$0x"
      if (count_ff >= 3'd3) begin
         if (!hv[4]) begin
            flags_in[1] = 1'b0;
         end else begin
            long_in = (long_sum > LongSat) ? LongSat[LongW-1:0] : long_sum[LongW-1:0];
         end
      end
      if (dot_ff == 3'd0) begin
         if (char_in == ".") begin
            dot_in = 3'd1;
         end
      end else begin
         if (k < 3'd3) begin
            suffix_in[k[1:0]] = char_in;
         end
         if (dot_ff < 3'd5) begin
            dot_in = dot_ff + 3'd1;
         end
      end
   end

   always_comb begin
      long_wide       = {24'd0, long_in};
      view.count      = count_in;
      view.head       = head_in;
      view.all_digits = all_digits_in;
      view.dec_over   = dec_in[8];
      view.dec_val    = dec_in[7:0];
      view.short_over = short_in[8];
      view.short_val  = short_in[7:0];
      view.long_over  = long_in[ADDRESS_BITS];
      view.long_val   = long_wide[23:0];
      view.hex_flags  = flags_in;
      view.dot_state  = dot_in;
      view.suffix     = suffix_in;
   end

   always_ff @(posedge clock) begin
      if (reset || (step && clear)) begin
         count_ff      <= '0;
         head_ff       <= '0;
         all_digits_ff <= 1'b1;
         dec_ff        <= '0;
         short_ff      <= '0;
         long_ff       <= '0;
         flags_ff      <= 2'b11;
         dot_ff        <= '0;
         suffix_ff     <= '0;
      end else if (step) begin
         count_ff      <= count_in;
         head_ff       <= head_in;
         all_digits_ff <= all_digits_in;
         dec_ff        <= dec_in;
         short_ff      <= short_in;
         long_ff       <= long_in;
         flags_ff      <= flags_in;
         dot_ff        <= dot_in;
         suffix_ff     <= suffix_in;
      end
   end

endmodule
